FILE: hw/rtl/sfe_pkg.sv
// package for the servo command frame encoder
// constants and types shared by all rtl files, and the divide-by-ten helper used by the front end
// no dependencies
package sfe_pkg;

	// stream widths
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 8;

	// input word layout, lowest bit first
	localparam int CMD_LSB    = 0;
	localparam int CMD_W      = 2;
	localparam int POS_LSB    = 2;
	localparam int ANGLE_W    = 24;
	localparam int SPEED_LSB  = 26;
	localparam int SPEED_W    = 17;
	localparam int SECTOR_LSB = 43;

	// command codes
	localparam logic [CMD_W-1:0] MODE_POS   = 2'd0;
	localparam logic [CMD_W-1:0] MODE_CW    = 2'd1;
	localparam logic [CMD_W-1:0] MODE_CCW   = 2'd2;
	localparam logic [CMD_W-1:0] MODE_SWEEP = 2'd3;

	// frame bytes
	localparam logic [7:0] SYNC0      = 8'hFF;
	localparam logic [7:0] SYNC1      = 8'hAA;
	localparam logic [7:0] SYNC2      = 8'h55;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	// frame byte positions
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] BYTE_SYNC0  = 5'd0;
	localparam logic [CNT_W-1:0] BYTE_SYNC1  = 5'd1;
	localparam logic [CNT_W-1:0] BYTE_SYNC2  = 5'd2;
	localparam logic [CNT_W-1:0] BYTE_MODE   = 5'd3;
	localparam logic [CNT_W-1:0] BYTE_DIGIT0 = 5'd4;
	localparam logic [CNT_W-1:0] BYTE_LAST   = 5'd17;

	// angle wrap: bias makes any 24-bit angle positive, then restoring mod
	localparam int ACC_W = 25;
	localparam logic [ACC_W-1:0] TURN      = 25'd36000;
	localparam logic [ACC_W-1:0] WRAP_BIAS = 25'd8640000;   // 240 turns
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] WRAP_LAST_STEP  = 4'd8;    // 36000 << 9 exceeds any biased value
	localparam logic [STEP_W-1:0] DIGIT_LAST_STEP = 4'd4;    // five digits per lane

	// scaling: pos = floor(w*5/18), sector = floor(w*5/36), reciprocal then fix
	localparam int SCALE_W = 18;
	localparam int PROD_W  = 36;
	localparam logic [SCALE_W-1:0] POS_RECIP = 18'd233016;   // floor(2^22/18)
	localparam logic [SCALE_W-1:0] SEC_RECIP = 18'd233016;   // floor(2^23/36)
	localparam logic [SCALE_W-1:0] POS_DIV   = 18'd18;
	localparam logic [SCALE_W-1:0] SEC_DIV   = 18'd36;
	localparam int POS_Q_W = 14;
	localparam int SEC_Q_W = 13;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 17'd99999;

	// decimal lanes
	localparam int LANES     = 3;
	localparam int LANE_POS  = 0;
	localparam int LANE_SPD  = 1;
	localparam int LANE_SEC  = 2;
	localparam int BCD_W     = 20;
	localparam int SEC_BCD_W = 16;
	localparam int BCD_DIGITS = 14;
	localparam logic [SPEED_W-1:0] DIV10_RECIP = 17'd52428;  // floor(2^19/10)

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_WRAP,
		FE_MUL,
		FE_FIX,
		FE_DIGIT,
		FE_HOLD
	} fe_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]     mode;
		logic [BCD_W-1:0]     pos_bcd;
		logic [BCD_W-1:0]     speed_bcd;
		logic [SEC_BCD_W-1:0] sector_bcd;
	} frame_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [SPEED_W-1:0] q;
		logic [3:0]         r;
	} div10_t;

	// v / 10 and v % 10 for 17-bit v: reciprocal estimate is low by at most one
	function automatic div10_t div10(input logic [SPEED_W-1:0] v);
		logic [2*SPEED_W-1:0] prod;
		logic [SPEED_W-1:0]   q0;
		logic [SPEED_W-1:0]   rem;
		div10_t               res;
		prod = (2*SPEED_W)'(v) * (2*SPEED_W)'(DIV10_RECIP);
		q0   = SPEED_W'(prod >> 19);
		rem  = v - (q0 << 3) - (q0 << 1);
		if (rem >= SPEED_W'(10)) begin
			res.q = q0 + SPEED_W'(1);
			res.r = 4'(rem - SPEED_W'(10));
		end else begin
			res.q = q0;
			res.r = 4'(rem);
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/sfe_front.sv
// front end: accepts a command, wraps and scales the angles, splits into digits
// depends on sfe_pkg
module sfe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sfe_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                          push,
	output sfe_pkg::frame_entry_t         entry,
	input  sfe_pkg::queue_stat_t          qstat
);

	sfe_pkg::fe_state_t state_q, state_d;
	logic [sfe_pkg::STEP_W-1:0]  step_q;
	logic [sfe_pkg::CMD_W-1:0]   mode_q;
	logic [sfe_pkg::ACC_W-1:0]   pacc_q, sacc_q;
	logic [sfe_pkg::SPEED_W-1:0] speed_q;
	logic [sfe_pkg::PROD_W-1:0]  pprod_q, sprod_q;
	logic [sfe_pkg::SPEED_W-1:0] lane_q [sfe_pkg::LANES];
	logic [sfe_pkg::BCD_W-1:0]   bcd_q  [sfe_pkg::LANES];

	logic                         accept;
	logic [sfe_pkg::CMD_W-1:0]    in_cmd;
	logic [sfe_pkg::ANGLE_W-1:0]  in_pos, in_sec;
	logic [sfe_pkg::SPEED_W-1:0]  in_speed;
	logic [sfe_pkg::ACC_W-1:0]    limit;
	logic [sfe_pkg::SCALE_W-1:0]  pn, sn, prem, srem;
	logic [sfe_pkg::POS_Q_W-1:0]  pq0, pq;
	logic [sfe_pkg::SEC_Q_W-1:0]  sq0, sq;
	sfe_pkg::div10_t              dv [sfe_pkg::LANES];

	assign in_cmd   = s_tdata[sfe_pkg::CMD_LSB +: sfe_pkg::CMD_W];
	assign in_pos   = s_tdata[sfe_pkg::POS_LSB +: sfe_pkg::ANGLE_W];
	assign in_speed = s_tdata[sfe_pkg::SPEED_LSB +: sfe_pkg::SPEED_W];
	assign in_sec   = s_tdata[sfe_pkg::SECTOR_LSB +: sfe_pkg::ANGLE_W];
	assign accept   = s_tvalid && s_tready;

	// restoring modulo step limit
	assign limit = sfe_pkg::TURN << step_q;

	// times five, then reciprocal estimate and one correction
	assign pn   = {pacc_q[15:0], 2'b00} + sfe_pkg::SCALE_W'(pacc_q[15:0]);
	assign sn   = {sacc_q[15:0], 2'b00} + sfe_pkg::SCALE_W'(sacc_q[15:0]);
	assign pq0  = pprod_q[22 +: sfe_pkg::POS_Q_W];
	assign sq0  = sprod_q[23 +: sfe_pkg::SEC_Q_W];
	assign prem = pn - sfe_pkg::SCALE_W'(sfe_pkg::SCALE_W'(pq0) * sfe_pkg::POS_DIV);
	assign srem = sn - sfe_pkg::SCALE_W'(sfe_pkg::SCALE_W'(sq0) * sfe_pkg::SEC_DIV);
	assign pq   = (prem >= sfe_pkg::POS_DIV) ? pq0 + sfe_pkg::POS_Q_W'(1) : pq0;
	assign sq   = (srem >= sfe_pkg::SEC_DIV) ? sq0 + sfe_pkg::SEC_Q_W'(1) : sq0;

	always_comb begin
		for (int i = 0; i < sfe_pkg::LANES; i++) begin
			dv[i] = sfe_pkg::div10(lane_q[i]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfe_pkg::FE_IDLE:  if (accept) state_d = sfe_pkg::FE_WRAP;
			sfe_pkg::FE_WRAP:  if (step_q == '0) state_d = sfe_pkg::FE_MUL;
			sfe_pkg::FE_MUL:   state_d = sfe_pkg::FE_FIX;
			sfe_pkg::FE_FIX:   state_d = sfe_pkg::FE_DIGIT;
			sfe_pkg::FE_DIGIT: if (step_q == '0) state_d = sfe_pkg::FE_HOLD;
			sfe_pkg::FE_HOLD:  if (!qstat.full) state_d = sfe_pkg::FE_IDLE;
			default:           state_d = sfe_pkg::FE_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		push     = 1'b0;
		case (state_q)
			sfe_pkg::FE_IDLE: s_tready = 1'b1;
			sfe_pkg::FE_HOLD: push     = !qstat.full;
			default: begin
				s_tready = 1'b0;
				push     = 1'b0;
			end
		endcase
	end

	assign entry.mode       = mode_q;
	assign entry.pos_bcd    = bcd_q[sfe_pkg::LANE_POS];
	assign entry.speed_bcd  = bcd_q[sfe_pkg::LANE_SPD];
	assign entry.sector_bcd = bcd_q[sfe_pkg::LANE_SEC][sfe_pkg::SEC_BCD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfe_pkg::FE_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sfe_pkg::FE_IDLE:  step_q <= sfe_pkg::WRAP_LAST_STEP;
				sfe_pkg::FE_FIX:   step_q <= sfe_pkg::DIGIT_LAST_STEP;
				sfe_pkg::FE_WRAP,
				sfe_pkg::FE_DIGIT: step_q <= step_q - sfe_pkg::STEP_W'(1);
				default:           step_q <= step_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sfe_pkg::FE_IDLE: begin
				if (accept) begin
					mode_q  <= in_cmd;
					pacc_q  <= {in_pos[sfe_pkg::ANGLE_W-1], in_pos} + sfe_pkg::WRAP_BIAS;
					sacc_q  <= {in_sec[sfe_pkg::ANGLE_W-1], in_sec} + sfe_pkg::WRAP_BIAS;
					speed_q <= (in_speed > sfe_pkg::SPEED_MAX) ? sfe_pkg::SPEED_MAX : in_speed;
				end
			end
			sfe_pkg::FE_WRAP: begin
				if (pacc_q >= limit) pacc_q <= pacc_q - limit;
				if (sacc_q >= limit) sacc_q <= sacc_q - limit;
			end
			sfe_pkg::FE_MUL: begin
				pprod_q <= sfe_pkg::PROD_W'(pn) * sfe_pkg::PROD_W'(sfe_pkg::POS_RECIP);
				sprod_q <= sfe_pkg::PROD_W'(sn) * sfe_pkg::PROD_W'(sfe_pkg::SEC_RECIP);
			end
			sfe_pkg::FE_FIX: begin
				// position only in go-to and sweep, sector only in sweep
				lane_q[sfe_pkg::LANE_POS] <= (mode_q inside {sfe_pkg::MODE_POS, sfe_pkg::MODE_SWEEP})
					? sfe_pkg::SPEED_W'(pq) : '0;
				lane_q[sfe_pkg::LANE_SPD] <= speed_q;
				lane_q[sfe_pkg::LANE_SEC] <= (mode_q == sfe_pkg::MODE_SWEEP)
					? sfe_pkg::SPEED_W'(sq) : '0;
			end
			sfe_pkg::FE_DIGIT: begin
				// least significant digit first, shifted in from the top
				for (int i = 0; i < sfe_pkg::LANES; i++) begin
					lane_q[i] <= dv[i].q;
					bcd_q[i]  <= {dv[i].r, bcd_q[i][sfe_pkg::BCD_W-1:4]};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/sfe_queue.sv
// two-entry queue of encoded frames between front and back end
// depends on sfe_pkg
module sfe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sfe_pkg::frame_entry_t din,
	input  logic                  pop,
	output sfe_pkg::frame_entry_t dout,
	output sfe_pkg::queue_stat_t  qstat
);

	sfe_pkg::frame_entry_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign dout        = mem_q[rd_ptr_q];
	assign qstat.full  = count_q == 2'd2;
	assign qstat.empty = count_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/sfe_back.sv
// back end: walks one queued frame out as eighteen bytes, one per cycle while m_tready is high
// depends on sfe_pkg
module sfe_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sfe_pkg::frame_entry_t          head,
	input  sfe_pkg::queue_stat_t           qstat,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sfe_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	sfe_pkg::frame_entry_t             cur_q;
	logic                              active_q;
	logic [sfe_pkg::CNT_W-1:0]         cnt_q;
	logic                              tvalid_q, tlast_q;
	logic [sfe_pkg::OUT_DATA_W-1:0]    tdata_q;

	logic                                load, at_end;
	logic [sfe_pkg::OUT_DATA_W-1:0]      byte_d;
	logic [sfe_pkg::BCD_DIGITS*4-1:0]    all_bcd;
	logic [3:0]                          digit_idx;

	assign load      = !tvalid_q || m_tready;
	assign at_end    = cnt_q == sfe_pkg::BYTE_LAST;
	assign pop       = !qstat.empty && (!active_q || (load && at_end));
	assign all_bcd   = {cur_q.pos_bcd, cur_q.speed_bcd, cur_q.sector_bcd};
	assign digit_idx = 4'(cnt_q - sfe_pkg::BYTE_DIGIT0);

	always_comb begin
		case (cnt_q) inside
			sfe_pkg::BYTE_SYNC0: byte_d = sfe_pkg::SYNC0;
			sfe_pkg::BYTE_SYNC1: byte_d = sfe_pkg::SYNC1;
			sfe_pkg::BYTE_SYNC2: byte_d = sfe_pkg::SYNC2;
			sfe_pkg::BYTE_MODE:  byte_d = sfe_pkg::ASCII_ZERO | 8'(cur_q.mode);
			[sfe_pkg::BYTE_DIGIT0:sfe_pkg::BYTE_LAST]:
				byte_d = sfe_pkg::ASCII_ZERO
					| 8'(all_bcd[(sfe_pkg::BCD_DIGITS - 1 - int'(digit_idx)) * 4 +: 4]);
			default:             byte_d = '0;
		endcase
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (load && active_q) begin
				cnt_q <= cnt_q + sfe_pkg::CNT_W'(1);
				if (at_end) active_q <= 1'b0;
			end
			if (load) tvalid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (load && active_q) begin
			tdata_q <= byte_d;
			tlast_q <= at_end;
		end
	end

endmodule

FILE: hw/rtl/servo_command_frame_encoder.sv
// path: an accepted command passes the front end (9 wrap steps, multiply, fix-up,
// 5 digit steps, queue write), then the queue and the back end to its first frame byte
// output: one byte per cycle while m_axis_tready is high and frames are queued, set by the back end byte counter
// the front end takes the next command while the back end still sends the last frame
// reset: asynchronous, clears sequencer, counters and queue pointers; no clearing pass
module servo_command_frame_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	// command words
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [1:0] command, [25:2] position_centideg, [42:26] speed_tenths,
	// [66:43] sector_centideg, [71:67] zero
	input  logic [sfe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// frame bytes
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] tx_byte
	output logic [sfe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// last_byte of the frame
	output logic                           m_axis_tlast
);

	// encoded frame handed from front to back
	sfe_pkg::frame_entry_t q_din, q_head;
	sfe_pkg::queue_stat_t  q_stat;
	logic                  q_push, q_pop;

	// front: wrap, scale and decimal split, one command at a time
	sfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.push     (q_push),
		.entry    (q_din),
		.qstat    (q_stat)
	);

	// short queue so either side can stall on its own
	sfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_head),
		.qstat  (q_stat)
	);

	// back: header, mode digit and fourteen digits through a registered output
	sfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.qstat    (q_stat),
		.pop      (q_pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

	// the front end never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("frame queue written while full");

	// the back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("frame queue read while empty");

	// the front end is busy after taking a command and drops s_axis_tready
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("command taken while front end busy");

	// a byte following the end of a frame opens the next frame
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast)
		|=> (!m_axis_tvalid || m_axis_tdata == sfe_pkg::SYNC0))
		else $error("frame does not start with sync byte");

endmodule
